// ===== rtl/mf3_pkg.sv =====
// Shared types and constants of the 3x3 median filter.
package mf3_pkg;

  localparam int PIX_BITS = 8;
  localparam int ROW_BITS = 12;
  localparam int COL_BITS = 10;

  localparam int FW_BITS = 11;
  localparam int FH_BITS = 13;
  localparam int CFG_DW  = 13;
  localparam int CFG_IW  = 1;

  localparam int RESET_FRAME_WIDTH  = 1024;
  localparam int RESET_FRAME_HEIGHT = 1024;

  localparam int QDEPTH = 8;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IW-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_BITS-1:0] pix_t;
  typedef pix_t [8:0] window_t;

  typedef struct packed {
    logic                has_med;
    pix_t                med_pixel;
    logic [ROW_BITS-1:0] med_row;
    logic [COL_BITS-1:0] med_col;
    logic                has_border;
    pix_t                border_pixel;
    logic [ROW_BITS-1:0] border_row;
    logic [COL_BITS-1:0] border_col;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

// ===== rtl/mf3_median.sv =====
// Two-stage pipelined median-of-nine network built from column sorts.
module mf3_median (
  input  logic             clk,
  input  mf3_pkg::window_t win,
  output mf3_pkg::pix_t    med
);

  function automatic mf3_pkg::pix_t min2(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic mf3_pkg::pix_t max2(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic mf3_pkg::pix_t min3(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b,
                                         input mf3_pkg::pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic mf3_pkg::pix_t max3(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b,
                                         input mf3_pkg::pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic mf3_pkg::pix_t med3(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b,
                                         input mf3_pkg::pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  mf3_pkg::pix_t col_lo [3];
  mf3_pkg::pix_t col_mid [3];
  mf3_pkg::pix_t col_hi [3];
  mf3_pkg::pix_t lo_max;
  mf3_pkg::pix_t mid_med;
  mf3_pkg::pix_t hi_min;

  // Stage one sorts each window column; stage two reduces across the columns.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      col_lo[i]  <= min3(win[3*i], win[3*i+1], win[3*i+2]);
      col_mid[i] <= med3(win[3*i], win[3*i+1], win[3*i+2]);
      col_hi[i]  <= max3(win[3*i], win[3*i+1], win[3*i+2]);
    end
    lo_max  <= max3(col_lo[0], col_lo[1], col_lo[2]);
    mid_med <= med3(col_mid[0], col_mid[1], col_mid[2]);
    hi_min  <= min3(col_hi[0], col_hi[1], col_hi[2]);
  end

  assign med = med3(lo_max, mid_med, hi_min);

endmodule

// ===== rtl/mf3_queue.sv =====
// Small FIFO of classified work between the front and back halves.
module mf3_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  mf3_pkg::q_entry_t       push_entry,
  input  logic                    pop,
  output mf3_pkg::q_head_t        head,
  output logic [mf3_pkg::QCW-1:0] count
);

  localparam int PW = mf3_pkg::QPW;
  localparam int CW = mf3_pkg::QCW;

  mf3_pkg::q_entry_t slots [mf3_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

endmodule

// ===== rtl/mf3_front.sv =====
// Front half: size registers, position counters, line buffers, window and median pipeline.
module mf3_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [mf3_pkg::CFG_IW-1:0] cfg_index,
  input  logic [mf3_pkg::CFG_DW-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  mf3_pkg::pix_t              in_pixel,
  input  logic [mf3_pkg::QCW-1:0]    q_count,
  output logic                       q_push,
  output mf3_pkg::q_entry_t          q_entry
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int RB  = mf3_pkg::ROW_BITS;
  localparam int CB  = mf3_pkg::COL_BITS;
  localparam int SW  = mf3_pkg::QCW + 1;
  localparam int FWB = mf3_pkg::FW_BITS;
  localparam int FHB = mf3_pkg::FH_BITS;
  localparam int RST_W = (MAX_WIDTH < mf3_pkg::RESET_FRAME_WIDTH) ?
                         MAX_WIDTH : mf3_pkg::RESET_FRAME_WIDTH;
  localparam int RST_H = (MAX_HEIGHT < mf3_pkg::RESET_FRAME_HEIGHT) ?
                         MAX_HEIGHT : mf3_pkg::RESET_FRAME_HEIGHT;

  // Sizes are kept as the index of the last column and row, already clamped.
  logic [CW-1:0] last_col_idx;
  logic [RW-1:0] last_row_idx;
  logic [CW-1:0] last_col_idx_next;
  logic [RW-1:0] last_row_idx_next;
  logic [FWB-1:0] cfg_w;
  logic [FHB-1:0] cfg_h;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          accept;
  logic          at_last_col;
  logic          at_last_row;
  logic          is_border;
  logic          has_med;

  logic          s1_valid;
  mf3_pkg::pix_t s1_pix;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic          s1_border;
  logic          s1_med;
  logic          s1_fwd;
  mf3_pkg::pix_t s1_fwd_mid;
  mf3_pkg::pix_t s1_fwd_top;
  mf3_pkg::pix_t rd_mid;
  mf3_pkg::pix_t rd_top;
  mf3_pkg::pix_t mid_eff;
  mf3_pkg::pix_t top_eff;

  logic          s2_valid;
  mf3_pkg::pix_t s2_pix;
  logic [CW-1:0] s2_col;
  logic [RW-1:0] s2_row;
  logic          s2_border;
  logic          s2_med;

  logic          s3_valid;
  mf3_pkg::pix_t s3_pix;
  logic [CW-1:0] s3_col;
  logic [RW-1:0] s3_row;
  logic          s3_border;
  logic          s3_med;

  mf3_pkg::pix_t   win_cols [6];
  mf3_pkg::window_t win;
  mf3_pkg::pix_t   med;

  mf3_pkg::pix_t mid_mem [MAX_WIDTH];
  mf3_pkg::pix_t top_mem [MAX_WIDTH];

  assign cfg_w = cfg_data[FWB-1:0];
  assign cfg_h = cfg_data[FHB-1:0];

  always_comb begin
    if (cfg_w == '0) begin
      last_col_idx_next = '0;
    end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
      last_col_idx_next = CW'(MAX_WIDTH - 1);
    end else begin
      last_col_idx_next = CW'(32'(cfg_w) - 32'd1);
    end
    if (cfg_h == '0) begin
      last_row_idx_next = '0;
    end else if (32'(cfg_h) > 32'(MAX_HEIGHT)) begin
      last_row_idx_next = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row_idx_next = RW'(32'(cfg_h) - 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col_idx <= CW'(RST_W - 1);
      last_row_idx <= RW'(RST_H - 1);
    end else if (cfg_write) begin
      case (mf3_pkg::cfg_reg_t'(cfg_index))
        mf3_pkg::REG_FRAME_WIDTH: begin
          last_col_idx <= last_col_idx_next;
        end
        mf3_pkg::REG_FRAME_HEIGHT: begin
          last_row_idx <= last_row_idx_next;
        end
        default: begin
        end
      endcase
    end
  end

  // Every beat in flight may still need a queue slot, so count them all.
  assign in_stall = (SW'(q_count) + SW'(s1_valid) + SW'(s2_valid) + SW'(s3_valid))
                    >= SW'(mf3_pkg::QDEPTH);
  assign accept = in_valid && !in_stall;

  assign at_last_col = (col >= last_col_idx);
  assign at_last_row = (row >= last_row_idx);
  assign is_border   = (row == '0) || (col == '0) || at_last_col || at_last_row;
  assign has_med     = (row >= RW'(2)) && (col >= CW'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (at_last_col) begin
          col <= '0;
          row <= at_last_row ? '0 : row + RW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix    <= in_pixel;
      s1_col    <= col;
      s1_row    <= row;
      s1_border <= is_border;
      s1_med    <= has_med;
    end
    // The beat ahead writes this same column at the edge of our read.
    s1_fwd     <= s1_valid && (s1_col == col);
    s1_fwd_mid <= s1_pix;
    s1_fwd_top <= mid_eff;

    s2_pix    <= s1_pix;
    s2_col    <= s1_col;
    s2_row    <= s1_row;
    s2_border <= s1_border;
    s2_med    <= s1_med;

    s3_pix    <= s2_pix;
    s3_col    <= s2_col;
    s3_row    <= s2_row;
    s3_border <= s2_border;
    s3_med    <= s2_med;
  end

  // Line buffers: mid holds the row above, top the row two above.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      top_mem[s1_col] <= mid_eff;
      mid_mem[s1_col] <= s1_pix;
    end
    if (accept) begin
      rd_mid <= mid_mem[col];
      rd_top <= top_mem[col];
    end
  end

  assign mid_eff = s1_fwd ? s1_fwd_mid : rd_mid;
  assign top_eff = s1_fwd ? s1_fwd_top : rd_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win_cols[i] <= '0;
      end
    end else if (s1_valid) begin
      win_cols[3] <= win_cols[0];
      win_cols[4] <= win_cols[1];
      win_cols[5] <= win_cols[2];
      win_cols[0] <= top_eff;
      win_cols[1] <= mid_eff;
      win_cols[2] <= s1_pix;
    end
  end

  assign win[0] = win_cols[3];
  assign win[1] = win_cols[4];
  assign win[2] = win_cols[5];
  assign win[3] = win_cols[0];
  assign win[4] = win_cols[1];
  assign win[5] = win_cols[2];
  assign win[6] = top_eff;
  assign win[7] = mid_eff;
  assign win[8] = s1_pix;

  mf3_median u_median (
    .clk (clk),
    .win (win),
    .med (med)
  );

  assign q_push = s3_valid && (s3_med || s3_border);

  always_comb begin
    q_entry.has_med      = s3_med;
    q_entry.med_pixel    = med;
    q_entry.med_row      = RB'(s3_row - RW'(1));
    q_entry.med_col      = CB'(s3_col - CW'(1));
    q_entry.has_border   = s3_border;
    q_entry.border_pixel = s3_pix;
    q_entry.border_row   = RB'(s3_row);
    q_entry.border_col   = CB'(s3_col);
  end

endmodule

// ===== rtl/mf3_back.sv =====
// Back half: turns each queued entry into one or two result beats on the output register.
module mf3_back (
  input  logic                            clk,
  input  logic                            rst,
  input  mf3_pkg::q_head_t                head,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mf3_pkg::pix_t                   out_pixel,
  output logic [mf3_pkg::ROW_BITS-1:0]    out_row,
  output logic [mf3_pkg::COL_BITS-1:0]    out_col,
  output logic                            out_is_border,
  output logic                            out_last
);

  logic load;
  logic take_med;
  logic med_done;

  assign load     = !out_valid || !out_stall;
  assign take_med = head.entry.has_med && !med_done;
  assign pop      = load && head.valid && !(take_med && head.entry.has_border);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      med_done  <= 1'b0;
    end else if (load) begin
      out_valid <= head.valid;
      if (head.valid) begin
        med_done <= take_med && head.entry.has_border;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head.valid) begin
      if (take_med) begin
        out_pixel     <= head.entry.med_pixel;
        out_row       <= head.entry.med_row;
        out_col       <= head.entry.med_col;
        out_is_border <= 1'b0;
        out_last      <= !head.entry.has_border;
      end else begin
        out_pixel     <= head.entry.border_pixel;
        out_row       <= head.entry.border_row;
        out_col       <= head.entry.border_col;
        out_is_border <= 1'b1;
        out_last      <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/median_filter_3x3_gray_core.sv =====
// 3x3 median filter core: takes one pixel per clock while in_stall is low; a result beat goes
// through stages s1 to s3, the queue and the output register. A pixel that is both the
// bottom-right neighbor of an interior pixel and a border pixel gives two beats, which the
// single output register sends one after the other; this one-beat-per-cycle port limits throughput.
// Reset is synchronous: it clears counters, window and queue and sets both sizes to 1024 (capped at
// MAX_WIDTH and MAX_HEIGHT); the line buffers are not cleared.
module median_filter_3x3_gray_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mf3_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [mf3_pkg::CFG_DW-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mf3_pkg::PIX_BITS-1:0]    in_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mf3_pkg::PIX_BITS-1:0]    out_pixel,
  output logic [mf3_pkg::ROW_BITS-1:0]    out_row,
  output logic [mf3_pkg::COL_BITS-1:0]    out_col,
  output logic                            out_is_border,
  output logic                            out_last
);

  logic                    q_push;
  logic                    q_pop;
  mf3_pkg::q_entry_t       q_entry;
  mf3_pkg::q_head_t        q_head;
  logic [mf3_pkg::QCW-1:0] q_count;

  mf3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  mf3_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .count      (q_count)
  );

  mf3_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel     (out_pixel),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_is_border (out_is_border),
    .out_last      (out_last)
  );

  // The input throttle must leave room for every beat still in the front pipeline.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (q_count == mf3_pkg::QCW'(mf3_pkg::QDEPTH)) |-> !q_push)
    else $error("queue push while full");

  a_border_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_is_border) |-> out_last)
    else $error("border copy beat not marked last");

  a_median_then_border: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_last) |=> (out_valid && out_is_border))
    else $error("median beat not followed by its border copy");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_count != '0))
    else $error("queue pop while empty");

endmodule
